// ----- hw/rtl/slse_pkg.sv -----
// slse_pkg: shared types for the sorted list engine.
// Command codes and controller states; no dependencies.
package slse_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    typedef enum logic [1:0] {
        CMD_INSERT     = 2'd0,
        CMD_REMOVE_EQ  = 2'd1,
        CMD_REMOVE_MAX = 2'd2,
        CMD_QUERY      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_REM_RD,
        ST_REM_CMP,
        ST_MID,
        ST_OUT
    } state_t;

endpackage

// ----- hw/rtl/slse_mem.sv -----
// slse_mem: entry store, one write port and one read port, registered read data.
// Depends on slse_pkg for the data width.
module slse_mem #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [ADDR_W-1:0]               wr_addr,
    input  logic signed [slse_pkg::DATA_W-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [ADDR_W-1:0]               rd_addr,
    output logic signed [slse_pkg::DATA_W-1:0] rd_data
);
    import slse_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/slse_ctrl.sv -----
// slse_ctrl: command sequencer; walks the entry store to insert or compact,
// then reads the middle entry and registers the result. Depends on slse_pkg.
module slse_ctrl #(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned ADDR_W   = 6,
    parameter int unsigned CNT_W    = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         command,
    input  logic signed [slse_pkg::DATA_W-1:0] value,
    output logic                               done,
    output logic [slse_pkg::COUNT_W-1:0]       entry_count,
    output logic                               middle_present,
    output logic signed [slse_pkg::DATA_W-1:0] middle_value,
    output logic                               overflow,
    output logic                               mem_wr_en,
    output logic [ADDR_W-1:0]                  mem_wr_addr,
    output logic signed [slse_pkg::DATA_W-1:0] mem_wr_data,
    output logic                               mem_rd_en,
    output logic [ADDR_W-1:0]                  mem_rd_addr,
    input  logic signed [slse_pkg::DATA_W-1:0] mem_rd_data
);
    import slse_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         wr_reg, wr_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     ovf_reg, ovf_next;

    logic                     done_reg;
    logic [COUNT_W-1:0]       cnt_out_reg;
    logic                     present_reg;
    logic signed [DATA_W-1:0] middle_reg;
    logic                     ovf_out_reg;

    logic                     has_middle;

    assign has_middle = (count_reg >= CNT_W'(3));

    // next state and working registers
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        wr_next    = wr_reg;
        key_next   = key_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next = value;
                    ovf_next = 1'b0;
                    unique case (cmd_t'(command))
                        CMD_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                ovf_next   = 1'b1;
                                state_next = ST_MID;
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                count_next = count_reg + CNT_W'(1);
                                state_next = ST_INS_RD;
                            end
                        end
                        CMD_REMOVE_EQ:
                        begin
                            pos_next   = '0;
                            wr_next    = '0;
                            state_next = ST_REM_RD;
                        end
                        CMD_REMOVE_MAX:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            state_next = ST_MID;
                        end
                        CMD_QUERY:
                        begin
                            state_next = ST_MID;
                        end
                    endcase
                end
            end
            ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = ST_MID;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (mem_rd_data > key_reg)
                begin
                    pos_next   = pos_reg - CNT_W'(1);
                    state_next = ST_INS_RD;
                end
                else
                begin
                    state_next = ST_MID;
                end
            end
            ST_REM_RD:
            begin
                if (pos_reg == count_reg)
                begin
                    count_next = wr_reg;
                    state_next = ST_MID;
                end
                else
                begin
                    state_next = ST_REM_CMP;
                end
            end
            ST_REM_CMP:
            begin
                if (mem_rd_data != key_reg)
                begin
                    wr_next = wr_reg + CNT_W'(1);
                end
                pos_next   = pos_reg + CNT_W'(1);
                state_next = ST_REM_RD;
            end
            ST_MID:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port drive
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = key_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        unique case (state_reg)
            ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = '0;
                    mem_wr_data = key_reg;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ADDR_W'(pos_reg - CNT_W'(1));
                end
            end
            ST_INS_CMP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ADDR_W'(pos_reg);
                mem_wr_data = (mem_rd_data > key_reg) ? mem_rd_data : key_reg;
            end
            ST_REM_RD:
            begin
                mem_rd_en   = (pos_reg != count_reg);
                mem_rd_addr = ADDR_W'(pos_reg);
            end
            ST_REM_CMP:
            begin
                mem_wr_en   = (mem_rd_data != key_reg);
                mem_wr_addr = ADDR_W'(wr_reg);
                mem_wr_data = mem_rd_data;
            end
            ST_MID:
            begin
                mem_rd_en   = has_middle;
                mem_rd_addr = ADDR_W'(count_reg >> 1);
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            wr_reg    <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            wr_reg    <= wr_next;
            ovf_reg   <= ovf_next;
            done_reg  <= (state_reg == ST_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (state_reg == ST_OUT)
        begin
            cnt_out_reg <= COUNT_W'(count_reg);
            present_reg <= has_middle;
            middle_reg  <= has_middle ? mem_rd_data : '0;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign entry_count    = cnt_out_reg;
    assign middle_present = present_reg;
    assign middle_value   = middle_reg;
    assign overflow       = ovf_out_reg;

endmodule

// ----- hw/rtl/sorted_list_engine_unit.sv -----
// Sorted list engine: bounded ascending list of signed words in one memory.
// Query, remove-largest and an insert into a full list go straight to the
// middle-entry read; insert walks down over the entries above the new value,
// remove-equal over every entry, each step a read then a compare. One command
// at a time: busy stays high until the result is registered; the next command
// can be taken in the cycle done pulses. Reset empties the list.
module sorted_list_engine_unit #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         command,
    input  logic signed [slse_pkg::DATA_W-1:0] value,
    output logic                               done,
    output logic [slse_pkg::COUNT_W-1:0]       entry_count,
    output logic                               middle_present,
    output logic signed [slse_pkg::DATA_W-1:0] middle_value,
    output logic                               overflow
);
    import slse_pkg::*;

    localparam int unsigned ADDR_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

    logic                     mem_wr_en;
    logic [ADDR_W-1:0]        mem_wr_addr;
    logic signed [DATA_W-1:0] mem_wr_data;
    logic                     mem_rd_en;
    logic [ADDR_W-1:0]        mem_rd_addr;
    logic signed [DATA_W-1:0] mem_rd_data;

    slse_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .value          (value),
        .done           (done),
        .entry_count    (entry_count),
        .middle_present (middle_present),
        .middle_value   (middle_value),
        .overflow       (overflow),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data)
    );

    slse_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
